// ----- sv/hrsp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrsp_pkg: shared types and constants of the HTTP request stream parser
// Result layout, tag codes and result-set container.
// ----------------------------------------------------------------------------
package hrsp_pkg;

    // Most results one received byte can cause
    localparam int MaxResults = 4;
    localparam int ResIdxW    = $clog2(MaxResults);
    localparam int ResCntW    = $clog2(MaxResults + 1);

    // Tag codes
    localparam logic [2:0] TAG_LINE_DONE = 3'd0;
    localparam logic [2:0] TAG_PATH      = 3'd1;
    localparam logic [2:0] TAG_QUERY     = 3'd2;
    localparam logic [2:0] TAG_NAME      = 3'd3;
    localparam logic [2:0] TAG_VALUE     = 3'd4;
    localparam logic [2:0] TAG_HDR_END   = 3'd5;
    localparam logic [2:0] TAG_BODY      = 3'd6;
    localparam logic [2:0] TAG_REQ_END   = 3'd7;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] tag;
        logic [2:0] method_code;
        logic [5:0] header_slot;
        logic       accepted;
        logic       parse_error;
        logic       has_body;
    } result_t;

    // All results of one byte, in delivery order from entry 0
    typedef struct packed {
        result_t [MaxResults-1:0] item;
        logic [ResCntW-1:0]       count;
    } result_set_t;

endpackage

// ----- sv/hrsp_parse.sv -----
// ----------------------------------------------------------------------------
// hrsp_parse: parser state and per-byte decode
// Computes every result of the registered byte in one pass.
// ----------------------------------------------------------------------------
module hrsp_parse
    import hrsp_pkg::*;
#(
    parameter int MaxHeaders  = 32,
    parameter int MethodChars = 7
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    input  logic        step_en,
    output result_set_t res_set
);

    localparam int NameCount   = 7;
    localparam int NameBytes   = 7;
    localparam int CaptureLen  = (MethodChars < NameBytes) ? MethodChars : NameBytes;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [2:0] METHOD_UNKNOWN = 3'd0;

    // GET POST PUT DELETE PATCH HEAD OPTIONS, right-aligned ASCII
    localparam logic [55:0] NAME_BITS [NameCount] = '{
        56'h474554, 56'h504F5354, 56'h505554, 56'h44454C455445,
        56'h5041544348, 56'h48454144, 56'h4F5054494F4E53
    };
    localparam logic [3:0] NAME_SIZE [NameCount] = '{
        4'd3, 4'd4, 4'd3, 4'd6, 4'd5, 4'd4, 4'd7
    };

    typedef enum logic [8:0] {
        PH_METHOD  = 9'b000000001,
        PH_PATH    = 9'b000000010,
        PH_QUERY   = 9'b000000100,
        PH_VERSION = 9'b000001000,
        PH_NAME    = 9'b000010000,
        PH_VSKIP   = 9'b000100000,
        PH_VALUE   = 9'b001000000,
        PH_BODY    = 9'b010000000,
        PH_ERROR   = 9'b100000000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [55:0] method_chars;
        logic [3:0]  method_count;
        logic [2:0]  method_found;
        logic        cr_held;
        logic [5:0]  header_total;
        logic        line_has_colon;
        logic        line_nonempty;
        logic        error_seen;
    } parse_state_t;

    typedef struct packed {
        parse_state_t st;
        logic         emit_v;
        result_t      item;
    } step_t;

    function automatic parse_state_t parse_reset();
        parse_state_t s;
        s = '0;
        s.phase = PH_METHOD;
        return s;
    endfunction

    function automatic result_t mk_item(input parse_state_t s, input logic [2:0] tag,
                                        input logic [7:0] b, input logic acc,
                                        input logic body);
        result_t r;
        r.out_byte    = b;
        r.tag         = tag;
        r.method_code = s.method_found;
        r.header_slot = s.header_total;
        r.accepted    = acc;
        r.parse_error = s.error_seen;
        r.has_body    = body;
        return r;
    endfunction

    function automatic logic [2:0] method_lookup(input logic [55:0] chars,
                                                 input logic [3:0] len);
        logic [2:0] code;
        code = METHOD_UNKNOWN;
        for (int i = 0; i < NameCount; i++) begin
            if (len == NAME_SIZE[i] && chars == NAME_BITS[i]) begin
                code = 3'(i + 1);
            end
        end
        return code;
    endfunction

    // One content byte through the current phase
    function automatic step_t feed(input parse_state_t s, input logic [7:0] c);
        step_t r;
        r.st     = s;
        r.emit_v = 1'b0;
        r.item   = mk_item(s, TAG_PATH, c, 1'b0, 1'b0);
        unique case (s.phase)
            PH_METHOD: begin
                if (c == CH_SP) begin
                    r.st.method_found = method_lookup(s.method_chars, s.method_count);
                    r.st.phase        = PH_PATH;
                end else begin
                    if (s.method_count < 4'(CaptureLen)) begin
                        r.st.method_chars = {s.method_chars[47:0], c};
                    end
                    if (s.method_count != 4'hF) begin
                        r.st.method_count = s.method_count + 4'd1;
                    end
                end
            end
            PH_PATH: begin
                if (c == CH_SP) begin
                    r.st.phase = PH_VERSION;
                end else if (c == CH_QMARK) begin
                    r.st.phase = PH_QUERY;
                end else begin
                    r.emit_v = 1'b1;
                end
            end
            PH_QUERY: begin
                if (c == CH_SP) begin
                    r.st.phase = PH_VERSION;
                end else begin
                    r.emit_v   = 1'b1;
                    r.item.tag = TAG_QUERY;
                end
            end
            PH_NAME: begin
                r.st.line_nonempty = 1'b1;
                if (c == CH_COLON) begin
                    r.st.line_has_colon = 1'b1;
                    r.st.phase          = PH_VSKIP;
                end else begin
                    r.emit_v   = 1'b1;
                    r.item.tag = TAG_NAME;
                end
            end
            PH_VSKIP: begin
                if (c != CH_SP) begin
                    r.st.phase = PH_VALUE;
                    r.emit_v   = 1'b1;
                    r.item.tag = TAG_VALUE;
                end
            end
            PH_VALUE: begin
                r.emit_v   = 1'b1;
                r.item.tag = TAG_VALUE;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // CRLF seen
    function automatic step_t crlf_step(input parse_state_t s);
        step_t r;
        logic  acc;
        r.st     = s;
        r.emit_v = 1'b0;
        r.item   = mk_item(s, TAG_LINE_DONE, 8'd0, 1'b0, 1'b0);
        acc      = s.line_has_colon && (s.header_total < 6'(MaxHeaders));
        if (s.phase == PH_METHOD || s.phase == PH_PATH || s.phase == PH_QUERY) begin
            r.st.error_seen = 1'b1;
            r.st.phase      = PH_ERROR;
        end else if (s.phase == PH_VERSION) begin
            r.emit_v            = 1'b1;
            r.st.line_has_colon = 1'b0;
            r.st.line_nonempty  = 1'b0;
            r.st.phase          = PH_NAME;
        end else if (!s.line_nonempty) begin
            r.st.phase = PH_BODY;
        end else begin
            r.emit_v        = 1'b1;
            r.item          = mk_item(s, TAG_HDR_END, 8'd0, acc, 1'b0);
            if (acc) begin
                r.st.header_total = s.header_total + 6'd1;
            end
            r.st.line_has_colon = 1'b0;
            r.st.line_nonempty  = 1'b0;
            r.st.phase          = PH_NAME;
        end
        return r;
    endfunction

    function automatic result_set_t push(input result_set_t rs, input result_t x);
        result_set_t r;
        r = rs;
        r.item[rs.count[ResIdxW-1:0]] = x;
        r.count = rs.count + ResCntW'(1);
        return r;
    endfunction

    parse_state_t st_reg, st_next;

    always_comb begin
        parse_state_t s;
        step_t        f;
        result_set_t  rs;
        s  = st_reg;
        rs = '0;
        f  = '0;

        if (s.phase == PH_BODY) begin
            rs = push(rs, mk_item(s, TAG_BODY, in_byte, 1'b0, 1'b0));
        end else if (s.phase != PH_ERROR) begin
            if (s.cr_held) begin
                s.cr_held = 1'b0;
                if (in_byte == CH_LF) begin
                    f = crlf_step(s);
                    s = f.st;
                    if (f.emit_v) rs = push(rs, f.item);
                end else begin
                    // lone CR counts as content, then the new byte
                    f = feed(s, CH_CR);
                    s = f.st;
                    if (f.emit_v) rs = push(rs, f.item);
                    if (in_byte == CH_CR) begin
                        s.cr_held = 1'b1;
                    end else begin
                        f = feed(s, in_byte);
                        s = f.st;
                        if (f.emit_v) rs = push(rs, f.item);
                    end
                end
            end else if (in_byte == CH_CR) begin
                s.cr_held = 1'b1;
            end else begin
                f = feed(s, in_byte);
                s = f.st;
                if (f.emit_v) rs = push(rs, f.item);
            end
        end

        if (in_end) begin
            if (s.cr_held && s.phase != PH_ERROR && s.phase != PH_BODY) begin
                f = feed(s, CH_CR);
                s = f.st;
                if (f.emit_v) rs = push(rs, f.item);
            end
            s.cr_held = 1'b0;
            if (s.phase == PH_METHOD || s.phase == PH_PATH || s.phase == PH_QUERY ||
                s.phase == PH_VERSION) begin
                s.error_seen = 1'b1;
                s.phase      = PH_ERROR;
            end else if ((s.phase == PH_NAME || s.phase == PH_VSKIP ||
                          s.phase == PH_VALUE) && s.line_nonempty) begin
                rs = push(rs, mk_item(s, TAG_HDR_END, 8'd0, 1'b0, 1'b0));
            end
            rs = push(rs, mk_item(s, TAG_REQ_END, 8'd0, 1'b0, s.phase == PH_BODY));
            s  = parse_reset();
        end

        st_next = s;
        res_set = rs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= parse_reset();
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

endmodule

// ----- sv/hrsp_rbuf.sv -----
// ----------------------------------------------------------------------------
// hrsp_rbuf: result buffer
// Holds the results of one byte and shifts them out one per handshake.
// ----------------------------------------------------------------------------
module hrsp_rbuf
    import hrsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_set_t res_set,
    input  logic        m_ready,
    output logic        m_valid,
    output result_t     head,
    output logic        head_last,
    output logic        free
);

    result_t [MaxResults-1:0] slot_reg, slot_next;
    logic [ResCntW-1:0]       cnt_reg, cnt_next;
    logic                     pop;

    assign pop       = (cnt_reg != '0) && m_ready;
    assign free      = (cnt_reg == '0) || ((cnt_reg == ResCntW'(1)) && m_ready);
    assign m_valid   = (cnt_reg != '0);
    assign head      = slot_reg[0];
    assign head_last = (cnt_reg == ResCntW'(1));

    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            slot_next = res_set.item;
            cnt_next  = res_set.count;
        end else if (pop) begin
            for (int i = 0; i < MaxResults - 1; i++) begin
                slot_next[i] = slot_reg[i+1];
            end
            cnt_next = cnt_reg - ResCntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

endmodule

// ----- sv/http_request_stream_parser.sv -----
// ----------------------------------------------------------------------------
// http_request_stream_parser: byte-stream HTTP/1.1 request head tagger
// Path: a taken byte waits in the input register, then its results are
//   loaded into the result buffer on m_*. Throughput: one byte per cycle
//   while the buffer is free; output handshakes set the pace. Reset: sync, active low.
// ----------------------------------------------------------------------------
module http_request_stream_parser
    import hrsp_pkg::*;
#(
    parameter int MaxHeaders  = 32,   // header lines kept per request
    parameter int MethodChars = 7     // method bytes kept for matching
)
(
    input  logic       aclk,
    input  logic       aresetn,

    // request bytes in
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_end,

    // tagged results out
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_tag,
    output logic [2:0] m_method_code,
    output logic [5:0] m_header_slot,
    output logic       m_accepted,
    output logic       m_parse_error,
    output logic       m_has_body,
    output logic       m_run_last
);

    // Input register: one request byte waits here while the parser state
    // and the result buffer decide whether it can go through this cycle.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    result_set_t res_set;
    result_t     head;
    logic        buf_free;
    logic        advance;

    // A byte that makes no result never waits on the output side. A byte
    // with results goes once the buffer empties, including the cycle its
    // last result is taken.
    assign advance = in_valid_reg && ((res_set.count == '0) || buf_free);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_end_reg  <= s_in_end;
        end
    end

    // Parser: phase, method capture, CR hold and header counters; state
    // moves only when the registered byte advances.
    hrsp_parse #(
        .MaxHeaders  (MaxHeaders),
        .MethodChars (MethodChars)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (in_byte_reg),
        .in_end  (in_end_reg),
        .step_en (advance),
        .res_set (res_set)
    );

    // Result buffer: up to four results of one byte, in order.
    hrsp_rbuf u_rbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && (res_set.count != '0)),
        .res_set   (res_set),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .head      (head),
        .head_last (m_run_last),
        .free      (buf_free)
    );

    assign m_out_byte    = head.out_byte;
    assign m_tag         = head.tag;
    assign m_method_code = head.method_code;
    assign m_header_slot = head.header_slot;
    assign m_accepted    = head.accepted;
    assign m_parse_error = head.parse_error;
    assign m_has_body    = head.has_body;

endmodule

// ----- sv/hrsp_checker.sv -----
// ----------------------------------------------------------------------------
// hrsp_checker: port-level checks of the request stream parser
// Watches reset, output hold and result grouping.
// ----------------------------------------------------------------------------
module hrsp_checker
    import hrsp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [2:0] m_tag,
    input logic [2:0] m_method_code,
    input logic [5:0] m_header_slot,
    input logic       m_accepted,
    input logic       m_parse_error,
    input logic       m_has_body,
    input logic       m_run_last
);

    // out of reset: nothing pending, input open
    assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("hrsp: not idle after reset");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_tag) &&
            $stable(m_method_code) && $stable(m_header_slot) && $stable(m_accepted) &&
            $stable(m_parse_error) && $stable(m_has_body) && $stable(m_run_last))
        else $error("hrsp: stalled result changed");

    // request end always closes its byte's results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_tag == TAG_REQ_END) |-> m_run_last)
        else $error("hrsp: request end not last");

    // remaining results of one byte follow without a gap
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("hrsp: gap inside a result group");

    // only a header line end can report a kept line
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> (m_tag == TAG_HDR_END))
        else $error("hrsp: accepted on wrong tag");

endmodule

bind http_request_stream_parser hrsp_checker u_hrsp_checker (.*);
